// File: hw/rtl/imu_afp_pkg.sv
// Shared types, constants and the centidegree conversion for the IMU angle frame parser.
package imu_afp_pkg;

    localparam int FRAME_BYTES = 11;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    localparam logic [POS_W-1:0] POS_IDLE  = '0;
    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
    localparam logic [POS_W-1:0] SUM_POS   = POS_W'(FRAME_BYTES - 1);

    localparam int TYPE_POS  = 1;
    localparam int ROLL_POS  = 2;
    localparam int PITCH_POS = 4;
    localparam int YAW_POS   = 6;
    localparam int TEMP_POS  = 8;
    localparam int LAST_DATA = FRAME_BYTES - 2;

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] ANGLE_TYPE  = 8'h53;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [15:0] LIMIT_RESET   = 16'd10;
    localparam logic [15:0] SILENCE_RESET = LIMIT_RESET + 16'd1;
    localparam logic [15:0] SILENCE_MAX   = 16'hFFFF;

    // 18000 / 32768 reduces to 1125 / 2048
    localparam int                 CDEG_SHIFT = 11;
    localparam int                 PROD_W     = 27;
    localparam logic signed [11:0] CDEG_MUL   = 12'sd1125;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] roll_val;
        logic signed [15:0] pitch_val;
        logic signed [15:0] yaw_raw;
        logic signed [15:0] roll_centi;
        logic signed [15:0] pitch_centi;
        logic signed [15:0] yaw_centi;
        logic signed [15:0] temperature_raw;
        logic        [31:0] angle_frames;
        logic        [31:0] checksum_errors;
        logic        [15:0] idle_ticks;
        logic               online;
    } t_out_item;

    function automatic logic signed [15:0] to_cdeg(input logic signed [15:0] raw);
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] biased;
        prod   = PROD_W'(raw) * PROD_W'(CDEG_MUL);
        biased = prod + (prod[PROD_W-1] ? PROD_W'((1 << CDEG_SHIFT) - 1) : PROD_W'(0));
        return biased[CDEG_SHIFT +: 16];
    endfunction

endpackage

// File: hw/rtl/imu_angle_frame_parser.sv
// IMU angle frame parser: byte and tick handling, frame checking and status snapshot.
//
// Takes one transaction per cycle while the output is not stalled, each a serial byte or
// a 10 ms tick, and returns one status snapshot per transaction. An input register feeds a
// single update stage whose result register is the parser state and drives the output;
// a running 8-bit checksum keeps each byte's work to one add and compare, so a full frame
// is judged when its checksum byte is processed.
// The centidegree values are worked out once when an angle frame is latched. The offline
// limit may be rewritten only while no transaction is in flight.
module imu_angle_frame_parser (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  imu_afp_pkg::t_in_item  i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output imu_afp_pkg::t_out_item o_out,
    input  logic                   i_cfg_wr_en,
    input  logic [15:0]            i_cfg_wr_data
);

    logic                         r_in_valid;
    imu_afp_pkg::t_in_item        r_in;
    logic                         r_out_valid;
    logic                         w_adv;
    logic                         w_step;

    logic [15:0]                  r_limit;

    logic [7:0]                   r_frame [imu_afp_pkg::TYPE_POS:imu_afp_pkg::LAST_DATA];
    logic                         w_frame_we;
    logic [7:0]                   r_sum,        n_sum;
    logic [imu_afp_pkg::POS_W-1:0] r_pos,       n_pos;

    logic signed [15:0]           r_roll,       n_roll;
    logic signed [15:0]           r_pitch,      n_pitch;
    logic signed [15:0]           r_yaw,        n_yaw;
    logic signed [15:0]           r_temp,       n_temp;
    logic signed [15:0]           r_roll_cdeg,  n_roll_cdeg;
    logic signed [15:0]           r_pitch_cdeg, n_pitch_cdeg;
    logic signed [15:0]           r_yaw_cdeg,   n_yaw_cdeg;
    logic [31:0]                  r_good_cnt,   n_good_cnt;
    logic [31:0]                  r_bad_cnt,    n_bad_cnt;
    logic [15:0]                  r_silence,    n_silence;
    logic                         r_seen,       n_seen;
    logic                         r_online,     n_online;
    logic                         w_angle_frame;

    logic signed [15:0]           w_roll_word;
    logic signed [15:0]           w_pitch_word;
    logic signed [15:0]           w_yaw_word;
    logic signed [15:0]           w_temp_word;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_step     = r_in_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= imu_afp_pkg::LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    assign w_roll_word  = {r_frame[imu_afp_pkg::ROLL_POS + 1],  r_frame[imu_afp_pkg::ROLL_POS]};
    assign w_pitch_word = {r_frame[imu_afp_pkg::PITCH_POS + 1], r_frame[imu_afp_pkg::PITCH_POS]};
    assign w_yaw_word   = {r_frame[imu_afp_pkg::YAW_POS + 1],   r_frame[imu_afp_pkg::YAW_POS]};
    assign w_temp_word  = {r_frame[imu_afp_pkg::TEMP_POS + 1],  r_frame[imu_afp_pkg::TEMP_POS]};

    always_comb begin
        n_sum         = r_sum;
        n_pos         = r_pos;
        n_roll        = r_roll;
        n_pitch       = r_pitch;
        n_yaw         = r_yaw;
        n_temp        = r_temp;
        n_roll_cdeg   = r_roll_cdeg;
        n_pitch_cdeg  = r_pitch_cdeg;
        n_yaw_cdeg    = r_yaw_cdeg;
        n_good_cnt    = r_good_cnt;
        n_bad_cnt     = r_bad_cnt;
        n_silence     = r_silence;
        n_seen        = r_seen;
        w_frame_we    = 1'b0;
        w_angle_frame = 1'b0;

        if (r_in.mode == imu_afp_pkg::MODE_TICK) begin
            if (r_silence != imu_afp_pkg::SILENCE_MAX) begin
                n_silence = r_silence + 16'd1;
            end
        end else if (r_pos == imu_afp_pkg::POS_IDLE) begin
            if (r_in.data_byte == imu_afp_pkg::HEADER_BYTE) begin
                n_pos = imu_afp_pkg::POS_FIRST;
                n_sum = r_in.data_byte;
            end
        end else if (r_pos == imu_afp_pkg::SUM_POS) begin
            n_pos = imu_afp_pkg::POS_IDLE;
            if (r_in.data_byte == r_sum) begin
                if (r_frame[imu_afp_pkg::TYPE_POS] == imu_afp_pkg::ANGLE_TYPE) begin
                    w_angle_frame = 1'b1;
                end
            end else begin
                n_bad_cnt = r_bad_cnt + 32'd1;
            end
        end else begin
            w_frame_we = 1'b1;
            n_sum      = r_sum + r_in.data_byte;
            n_pos      = r_pos + imu_afp_pkg::POS_FIRST;
        end

        if (w_angle_frame) begin
            n_roll       = w_roll_word;
            n_pitch      = w_pitch_word;
            n_yaw        = w_yaw_word;
            n_temp       = w_temp_word;
            n_roll_cdeg  = imu_afp_pkg::to_cdeg(w_roll_word);
            n_pitch_cdeg = imu_afp_pkg::to_cdeg(w_pitch_word);
            n_yaw_cdeg   = imu_afp_pkg::to_cdeg(w_yaw_word);
            n_good_cnt   = r_good_cnt + 32'd1;
            n_silence    = '0;
            n_seen       = 1'b1;
        end

        n_online = n_seen && (n_silence <= r_limit);
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_frame_we) begin
            r_frame[r_pos] <= r_in.data_byte;
        end
        if (w_step) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= imu_afp_pkg::POS_IDLE;
            r_roll       <= '0;
            r_pitch      <= '0;
            r_yaw        <= '0;
            r_temp       <= '0;
            r_roll_cdeg  <= '0;
            r_pitch_cdeg <= '0;
            r_yaw_cdeg   <= '0;
            r_good_cnt   <= '0;
            r_bad_cnt    <= '0;
            r_silence    <= imu_afp_pkg::SILENCE_RESET;
            r_seen       <= 1'b0;
            r_online     <= 1'b0;
        end else if (w_step) begin
            r_pos        <= n_pos;
            r_roll       <= n_roll;
            r_pitch      <= n_pitch;
            r_yaw        <= n_yaw;
            r_temp       <= n_temp;
            r_roll_cdeg  <= n_roll_cdeg;
            r_pitch_cdeg <= n_pitch_cdeg;
            r_yaw_cdeg   <= n_yaw_cdeg;
            r_good_cnt   <= n_good_cnt;
            r_bad_cnt    <= n_bad_cnt;
            r_silence    <= n_silence;
            r_seen       <= n_seen;
            r_online     <= n_online;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_out.roll_val        = r_roll;
    assign o_out.pitch_val       = r_pitch;
    assign o_out.yaw_raw         = r_yaw;
    assign o_out.roll_centi      = r_roll_cdeg;
    assign o_out.pitch_centi     = r_pitch_cdeg;
    assign o_out.yaw_centi       = r_yaw_cdeg;
    assign o_out.temperature_raw = r_temp;
    assign o_out.angle_frames    = r_good_cnt;
    assign o_out.checksum_errors = r_bad_cnt;
    assign o_out.idle_ticks      = r_silence;
    assign o_out.online          = r_online;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= imu_afp_pkg::SUM_POS)
        else $error("frame position beyond checksum byte");

    a_angle_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_angle_frame) |=> (r_silence == '0 && r_seen && o_out_valid))
        else $error("angle frame did not clear silence counter");

    a_online_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_online |-> r_seen)
        else $error("online without any angle frame");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input held off with free room");

    a_counts_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |=> ($stable(r_good_cnt) && $stable(r_bad_cnt) && $stable(r_silence)))
        else $error("counters moved without a transaction");

endmodule

// File: tb/tb_imu_angle_frame_parser.sv
// Self-checking testbench for imu_angle_frame_parser with a transaction-level status predictor.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_WAIT    = 13;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_ready;
    imu_afp_pkg::t_in_item  i_in          = '0;
    logic                   o_out_valid;
    logic                   i_out_ready   = 1'b0;
    imu_afp_pkg::t_out_item o_out;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [15:0]            i_cfg_wr_data = '0;

    imu_angle_frame_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in          (i_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out         (o_out),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // parser state as the block should hold it
    logic [15:0] exp_limit   = imu_afp_pkg::LIMIT_RESET;
    logic [7:0]  exp_frame [imu_afp_pkg::FRAME_BYTES];
    int          exp_pos     = 0;
    logic [15:0] exp_roll    = '0;
    logic [15:0] exp_pitch   = '0;
    logic [15:0] exp_yaw     = '0;
    logic [15:0] exp_temp    = '0;
    logic [31:0] exp_good    = '0;
    logic [31:0] exp_bad     = '0;
    logic [15:0] exp_silence = imu_afp_pkg::SILENCE_RESET;
    logic        exp_seen    = 1'b0;

    imu_afp_pkg::t_out_item snapshot_q [$];
    imu_afp_pkg::t_out_item snap_due;

    int          n_errors    = 0;
    int          n_items     = 0;
    int          n_checked   = 0;
    int          n_offline   = 0;
    int          cycle_count = 0;
    int          hold_cycles = 0;
    bit          tx_burst    = 1'b0;
    bit          rx_burst    = 1'b0;

    function automatic logic signed [15:0] cdeg_of(input logic [15:0] raw);
        int prod;
        prod = int'($signed(raw)) * 18000;
        return 16'(prod / 32768);
    endfunction

    task automatic advance_parser(input imu_afp_pkg::t_in_item item);
        imu_afp_pkg::t_out_item snap;
        logic [7:0]             sum;
        int                     i;
        if (item.mode == imu_afp_pkg::MODE_TICK) begin
            if (exp_silence != imu_afp_pkg::SILENCE_MAX) exp_silence++;
        end else if (exp_pos == 0) begin
            if (item.data_byte == imu_afp_pkg::HEADER_BYTE) begin
                exp_frame[0] = item.data_byte;
                exp_pos = 1;
            end
        end else begin
            exp_frame[exp_pos] = item.data_byte;
            exp_pos++;
            if (exp_pos == imu_afp_pkg::FRAME_BYTES) begin
                sum = '0;
                for (i = 0; i < imu_afp_pkg::FRAME_BYTES - 1; i++) sum += exp_frame[i];
                if (sum == exp_frame[imu_afp_pkg::FRAME_BYTES-1]) begin
                    if (exp_frame[imu_afp_pkg::TYPE_POS] == imu_afp_pkg::ANGLE_TYPE) begin
                        exp_roll    = {exp_frame[imu_afp_pkg::ROLL_POS+1],
                                       exp_frame[imu_afp_pkg::ROLL_POS]};
                        exp_pitch   = {exp_frame[imu_afp_pkg::PITCH_POS+1],
                                       exp_frame[imu_afp_pkg::PITCH_POS]};
                        exp_yaw     = {exp_frame[imu_afp_pkg::YAW_POS+1],
                                       exp_frame[imu_afp_pkg::YAW_POS]};
                        exp_temp    = {exp_frame[imu_afp_pkg::TEMP_POS+1],
                                       exp_frame[imu_afp_pkg::TEMP_POS]};
                        exp_good++;
                        exp_silence = '0;
                        exp_seen    = 1'b1;
                    end
                end else begin
                    exp_bad++;
                end
                exp_pos = 0;
            end
        end
        snap.roll_val        = exp_roll;
        snap.pitch_val       = exp_pitch;
        snap.yaw_raw         = exp_yaw;
        snap.roll_centi      = cdeg_of(exp_roll);
        snap.pitch_centi     = cdeg_of(exp_pitch);
        snap.yaw_centi       = cdeg_of(exp_yaw);
        snap.temperature_raw = exp_temp;
        snap.angle_frames    = exp_good;
        snap.checksum_errors = exp_bad;
        snap.idle_ticks      = exp_silence;
        snap.online          = exp_seen && (exp_silence <= exp_limit);
        if (exp_seen && !snap.online) n_offline++;
        snapshot_q.push_back(snap);
    endtask

    // hold valid high after a transaction when no gap follows
    task automatic send_item(input logic mode, input logic [7:0] data);
        imu_afp_pkg::t_in_item item;
        int                    gap;
        item.mode      = mode;
        item.data_byte = data;
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        advance_parser(item);
        n_items++;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] w_roll,
                              input logic [15:0] w_pitch, input logic [15:0] w_yaw,
                              input logic [15:0] w_temp, input bit bad_sum, input int tick_pct);
        logic [7:0] fb [imu_afp_pkg::FRAME_BYTES];
        logic [7:0] sum;
        int         i;
        fb[0]                          = imu_afp_pkg::HEADER_BYTE;
        fb[imu_afp_pkg::TYPE_POS]      = ftype;
        fb[imu_afp_pkg::ROLL_POS]      = w_roll[7:0];
        fb[imu_afp_pkg::ROLL_POS+1]    = w_roll[15:8];
        fb[imu_afp_pkg::PITCH_POS]     = w_pitch[7:0];
        fb[imu_afp_pkg::PITCH_POS+1]   = w_pitch[15:8];
        fb[imu_afp_pkg::YAW_POS]       = w_yaw[7:0];
        fb[imu_afp_pkg::YAW_POS+1]     = w_yaw[15:8];
        fb[imu_afp_pkg::TEMP_POS]      = w_temp[7:0];
        fb[imu_afp_pkg::TEMP_POS+1]    = w_temp[15:8];
        sum = '0;
        for (i = 0; i < imu_afp_pkg::FRAME_BYTES - 1; i++) sum += fb[i];
        fb[imu_afp_pkg::FRAME_BYTES-1] = bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        for (i = 0; i < imu_afp_pkg::FRAME_BYTES; i++) begin
            if (i > 0 && $urandom_range(0, 99) < tick_pct) begin
                send_item(imu_afp_pkg::MODE_TICK, 8'($urandom));
            end
            send_item(imu_afp_pkg::MODE_BYTE, fb[i]);
        end
    endtask

    // drop valid, let every snapshot come back, then allow the pipeline to settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (snapshot_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        exp_limit = value;
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_type();
        return ($urandom_range(0, 9) < 7) ? imu_afp_pkg::ANGLE_TYPE : 8'($urandom);
    endfunction

    task automatic test_idle_and_noise();
        repeat (3) send_item(imu_afp_pkg::MODE_TICK, 8'hFF);
        send_item(imu_afp_pkg::MODE_BYTE, 8'h00);
        send_item(imu_afp_pkg::MODE_BYTE, 8'hFF);
        send_item(imu_afp_pkg::MODE_BYTE, imu_afp_pkg::ANGLE_TYPE);
        send_item(imu_afp_pkg::MODE_TICK, 8'h00);
    endtask

    task automatic test_frame_extremes();
        send_frame(imu_afp_pkg::ANGLE_TYPE, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 1'b0, 0);
        send_frame(imu_afp_pkg::ANGLE_TYPE, 16'h5555, 16'h0000, 16'h0001, 16'h8000, 1'b0, 25);
        send_frame(8'h51, 16'h1234, 16'h4321, 16'h00FF, 16'hFF00, 1'b0, 0);
        send_frame(imu_afp_pkg::ANGLE_TYPE, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 1'b1, 0);
    endtask

    task automatic test_offline_limit();
        write_limit(16'd0);
        send_frame(imu_afp_pkg::ANGLE_TYPE, rand_word(), rand_word(), rand_word(), rand_word(),
                   1'b0, 0);
        repeat (2) send_item(imu_afp_pkg::MODE_TICK, 8'($urandom));
        write_limit(16'hFFFF);
        send_item(imu_afp_pkg::MODE_TICK, 8'($urandom));
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        repeat (40) send_item(imu_afp_pkg::MODE_TICK, 8'($urandom));
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        write_limit(16'd65534);
        send_item(imu_afp_pkg::MODE_TICK, 8'($urandom));
        write_limit(imu_afp_pkg::LIMIT_RESET);
        send_frame(imu_afp_pkg::ANGLE_TYPE, rand_word(), rand_word(), rand_word(), rand_word(),
                   1'b0, 0);
        repeat (13) send_item(imu_afp_pkg::MODE_TICK, 8'($urandom));
    endtask

    task automatic test_back_pressure();
        drain_results();
        hold_cycles = 250;
        tx_burst    = 1'b1;
        repeat (3) begin
            send_frame(imu_afp_pkg::ANGLE_TYPE, rand_word(), rand_word(), rand_word(),
                       rand_word(), 1'b0, 10);
            send_item(imu_afp_pkg::MODE_TICK, 8'($urandom));
        end
        tx_burst = 1'b0;
    endtask

    task automatic test_random_traffic();
        int phase;
        int stop_at;
        int pick;
        int i;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       write_limit(16'd0);
                1:       write_limit(16'd65534);
                2:       write_limit(16'hFFFF);
                default: write_limit(16'($urandom_range(1, 40)));
            endcase
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            stop_at  = n_items + 240;
            while (n_items < stop_at) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    send_frame(rand_type(), rand_word(), rand_word(), rand_word(), rand_word(),
                               $urandom_range(0, 9) == 0, $urandom_range(0, 1) * 8);
                end else if (pick < 80) begin
                    repeat ($urandom_range(1, 12)) begin
                        send_item(imu_afp_pkg::MODE_TICK, 8'($urandom));
                    end
                end else if (pick < 92) begin
                    repeat ($urandom_range(1, 4)) begin
                        send_item(imu_afp_pkg::MODE_BYTE, 8'($urandom));
                    end
                end else begin
                    // truncated frame: the next header lands inside it
                    send_item(imu_afp_pkg::MODE_BYTE, imu_afp_pkg::HEADER_BYTE);
                    for (i = $urandom_range(1, 9); i > 0; i--) begin
                        send_item(imu_afp_pkg::MODE_BYTE, 8'($urandom));
                    end
                end
            end
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // receiver: random stalls per transaction, long hold-off on request
    initial begin
        int stall;
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (snapshot_q.size() == 0) begin
                $error("snapshot transaction with none pending");
                n_errors++;
            end else begin
                snap_due = snapshot_q.pop_front();
                n_checked++;
                check_field("roll_val", snap_due.roll_val, o_out.roll_val);
                check_field("pitch_val", snap_due.pitch_val, o_out.pitch_val);
                check_field("yaw_raw", snap_due.yaw_raw, o_out.yaw_raw);
                check_field("roll_centi", snap_due.roll_centi, o_out.roll_centi);
                check_field("pitch_centi", snap_due.pitch_centi, o_out.pitch_centi);
                check_field("yaw_centi", snap_due.yaw_centi, o_out.yaw_centi);
                check_field("temperature_raw", snap_due.temperature_raw, o_out.temperature_raw);
                check_field("angle_frames", snap_due.angle_frames, o_out.angle_frames);
                check_field("checksum_errors", snap_due.checksum_errors, o_out.checksum_errors);
                check_field("idle_ticks", snap_due.idle_ticks, o_out.idle_ticks);
                check_field("online", snap_due.online, o_out.online);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("imu_angle_frame_parser test failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_and_noise();
        test_frame_extremes();
        test_offline_limit();
        test_back_pressure();
        test_random_traffic();
        drain_results();
        repeat (8) @(posedge i_clk);
        if (snapshot_q.size() != 0) begin
            $error("%0d snapshots never returned", snapshot_q.size());
            n_errors++;
        end
        $display("Sent %0d transactions and checked %0d snapshots in %0d cycles.",
                 n_items, n_checked, cycle_count);
        $display("Saw %0d angle frames, %0d checksum errors, %0d offline snapshots, %0d %s",
                 exp_good, exp_bad, n_offline, n_errors, "mismatches.");
        if (n_errors == 0) begin
            $display("imu_angle_frame_parser test passed");
        end else begin
            $display("imu_angle_frame_parser test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/imu_afp_pkg.sv
hw/rtl/imu_angle_frame_parser.sv
tb/tb_imu_angle_frame_parser.sv
